[design/bacon_case_stego_encoder_unit_defines.svh]
// Assertion macros for the Bacon case-steganography encoder.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef BACON_CASE_STEGO_ENCODER_UNIT_DEFINES_SVH
`define BACON_CASE_STEGO_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BCSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BCSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/bcse_pkg.sv]
// Shared types, constants and character functions for the Bacon encoder.
// Depends on nothing.
package bcse_pkg;

	localparam int unsigned CODE_W        = 5;
	localparam int unsigned BITS_PER_CODE = 5;
	localparam logic [2:0]  CODE_MSB_IDX  = 3'd4;

	// Request function codes
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_COVER = 1'b1;

	// Character constants
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_Z    = 8'h5A;
	localparam logic [7:0] CH_LO_A    = 8'h61;
	localparam logic [7:0] CH_LO_Z    = 8'h7A;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_QUERY   = 8'h3F;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CASE_BIT   = 8'h20;

	localparam logic [CODE_W-1:0] CODE_DOT   = 5'd26;
	localparam logic [CODE_W-1:0] CODE_SEMI  = 5'd27;
	localparam logic [CODE_W-1:0] CODE_BANG  = 5'd28;
	localparam logic [CODE_W-1:0] CODE_QUERY = 5'd29;
	localparam logic [CODE_W-1:0] CODE_ZERO  = 5'd30;
	localparam logic [CODE_W-1:0] CODE_SPACE = 5'd31;

	typedef struct packed {
		logic       func;
		logic [7:0] data;
		logic       last;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       all_placed;
		logic       end_of_text;
	} rsp_t;

	typedef struct packed {
		logic              hit;
		logic [CODE_W-1:0] code;
	} map_t;

	function automatic logic is_letter(input logic [7:0] ch);
		return ((ch >= CH_UP_A) && (ch <= CH_UP_Z)) || ((ch >= CH_LO_A) && (ch <= CH_LO_Z));
	endfunction

	function automatic map_t map_char(input logic [7:0] ch);
		logic [7:0] up;
		map_t       m;
		up = ((ch >= CH_LO_A) && (ch <= CH_LO_Z)) ? (ch & ~CASE_BIT) : ch;
		m.hit  = 1'b1;
		m.code = '0;
		priority if ((up >= CH_UP_A) && (up <= CH_UP_Z)) begin
			m.code = CODE_W'(up - CH_UP_A);
		end else if (up == CH_DOT) begin
			m.code = CODE_DOT;
		end else if (up == CH_SEMI) begin
			m.code = CODE_SEMI;
		end else if (up == CH_BANG) begin
			m.code = CODE_BANG;
		end else if (up == CH_QUERY) begin
			m.code = CODE_QUERY;
		end else if (up == CH_ZERO) begin
			m.code = CODE_ZERO;
		end else if (up == CH_SPACE) begin
			m.code = CODE_SPACE;
		end else begin
			m.hit = 1'b0;
		end
		return m;
	endfunction

endpackage

[design/bacon_case_stego_encoder_unit.sv]
// A cover request's response passes through the code read and then the output register;
//   a message request gives no response.
// Throughput: one request per cycle while not stalled; the single read port of the code memory serves one letter.
// Reset clears the fill count, read position and bit position; the code memory is not cleared,
//   as only entries written since the last reset or end of text are ever used.
// Depends on bcse_pkg, bcse_code_ram and bacon_case_stego_encoder_unit_defines.svh.
`include "bacon_case_stego_encoder_unit_defines.svh"

module bacon_case_stego_encoder_unit #(
	parameter int unsigned MSG_DEPTH = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  bcse_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output bcse_pkg::rsp_t  rsp
);

	localparam int unsigned CNT_W  = $clog2(MSG_DEPTH + 1);
	localparam int unsigned ADDR_W = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(MSG_DEPTH);

	// Control state: fill count, read position, bit position within the current code
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [2:0]       bit_q;

	// Stage 1: waiting on the code read
	logic       v_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       use_s1;
	logic       placed_s1;
	logic [2:0] bit_s1;

	// Stage 2: output register
	logic           v_s2;
	bcse_pkg::rsp_t rsp_s2;

	logic                        acc;
	logic                        adv_s1;
	logic                        load_req;
	logic                        cover_req;
	logic                        letter;
	logic                        use_bit;
	logic                        wr_en;
	logic [CNT_W-1:0]            rd_idx_nxt;
	logic [2:0]                  bit_nxt;
	logic                        placed;
	bcse_pkg::map_t              map;
	logic [bcse_pkg::CODE_W-1:0] code_rd;
	logic                        msg_bit;
	bcse_pkg::rsp_t              rsp_nxt;

	// Handshake: stage 1 moves on whenever the output register is free or draining
	assign adv_s1    = !v_s2 || !rsp_stall;
	assign req_stall = v_s1 && !adv_s1;
	assign acc       = req_valid && !req_stall;

	assign load_req  = acc && (req.func == bcse_pkg::FUNC_LOAD);
	assign cover_req = acc && (req.func == bcse_pkg::FUNC_COVER);

	// Message character: map, append while room remains, drop otherwise
	assign map   = bcse_pkg::map_char(req.data);
	assign wr_en = load_req && map.hit && (cnt_q < DEPTH_CNT);

	// Cover byte: a letter takes the next bit while codes remain
	assign letter  = bcse_pkg::is_letter(req.data);
	assign use_bit = letter && (rd_idx_q < cnt_q);

	always_comb begin
		rd_idx_nxt = rd_idx_q;
		bit_nxt    = bit_q;
		if (use_bit) begin
			if (bit_q == bcse_pkg::CODE_MSB_IDX) begin
				bit_nxt    = '0;
				rd_idx_nxt = rd_idx_q + CNT_W'(1);
			end else begin
				bit_nxt = bit_q + 3'd1;
			end
		end
	end

	assign placed = req.last && (rd_idx_nxt >= cnt_q) && (bit_nxt == '0);

	// Counters advance at acceptance, so the next request sees them at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			rd_idx_q <= '0;
			bit_q    <= '0;
		end else if (wr_en) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (cover_req) begin
			if (req.last) begin
				cnt_q    <= '0;
				rd_idx_q <= '0;
				bit_q    <= '0;
			end else begin
				rd_idx_q <= rd_idx_nxt;
				bit_q    <= bit_nxt;
			end
		end
	end

	// Writes and reads never share a cycle; a write is visible to a read issued next cycle
	bcse_code_ram #(
		.DEPTH  (MSG_DEPTH),
		.ADDR_W (ADDR_W)
	) u_code_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (map.code),
		.re    (cover_req),
		.raddr (rd_idx_q[ADDR_W-1:0]),
		.rdata (code_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cover_req) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cover_req) begin
			data_s1   <= req.data;
			last_s1   <= req.last;
			use_s1    <= use_bit;
			placed_s1 <= placed;
			bit_s1    <= bit_q;
		end
	end

	// Pick the message bit, MSB first, and set the case: one gives lower, zero upper
	assign msg_bit = code_rd[bcse_pkg::CODE_MSB_IDX - bit_s1];

	always_comb begin
		rsp_nxt.out_byte    = data_s1;
		rsp_nxt.all_placed  = placed_s1;
		rsp_nxt.end_of_text = last_s1;
		if (use_s1) begin
			rsp_nxt.out_byte = msg_bit ? (data_s1 | bcse_pkg::CASE_BIT)
			                           : (data_s1 & ~bcse_pkg::CASE_BIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s1) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && v_s1) begin
			rsp_s2 <= rsp_nxt;
		end
	end

	assign rsp_valid = v_s2;
	assign rsp       = rsp_s2;

	`BCSE_ASSERT_NOW(a_rd_within_fill, 1'b1, rd_idx_q <= cnt_q, "read position passed fill count")
	`BCSE_ASSERT_NOW(a_fill_bound, 1'b1, cnt_q <= DEPTH_CNT, "fill count exceeds buffer depth")
	`BCSE_ASSERT_NOW(a_mid_code, bit_q != 3'd0, rd_idx_q < cnt_q, "bit position inside no code")
	`BCSE_ASSERT_NEXT(a_clear_on_last, cover_req && req.last, (cnt_q == '0) && (rd_idx_q == '0) && (bit_q == 3'd0), "state not cleared after end of text")
	`BCSE_ASSERT_NOW(a_flag_only_last, rsp_valid && !rsp.end_of_text, !rsp.all_placed, "placed flag raised before end of text")

endmodule

[design/bcse_code_ram.sv]
// Code buffer memory: one write port, one registered read port.
// Depends on bcse_pkg for the code width.
module bcse_code_ram #(
	parameter int unsigned DEPTH  = 256,
	parameter int unsigned ADDR_W = 8
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [ADDR_W-1:0]          waddr,
	input  logic [bcse_pkg::CODE_W-1:0] wdata,
	input  logic                       re,
	input  logic [ADDR_W-1:0]          raddr,
	output logic [bcse_pkg::CODE_W-1:0] rdata
);

	logic [bcse_pkg::CODE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[tb/bacon_case_stego_encoder_unit_tb.sv]
// Self-checking testbench for bacon_case_stego_encoder_unit: random and directed requests
// are checked against a behavioural model of the case-steganography encoder.
// Depends on bcse_pkg and the encoder RTL only.
module bacon_case_stego_encoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MSG_DEPTH  = 256;
	localparam int unsigned STOP_AFTER = 2000;
	localparam int unsigned CYCLE_CAP  = 600000;
	localparam int unsigned LONG_HOLD  = 400;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            req_valid = 1'b0;
	logic            req_stall;
	bcse_pkg::req_t  req       = '0;
	logic            rsp_valid;
	logic            rsp_stall = 1'b0;
	bcse_pkg::rsp_t  rsp;

	bacon_case_stego_encoder_unit #(
		.MSG_DEPTH(MSG_DEPTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	// Requests waiting to be offered, and cover responses still owed by the block
	bcse_pkg::req_t request_backlog[$];
	bcse_pkg::rsp_t expected_cover[$];

	// Shadow of the encoder state
	logic [4:0]  code_buf [MSG_DEPTH];
	int unsigned code_fill = 0;
	int unsigned code_pos  = 0;
	logic [2:0]  bit_pos   = '0;

	int unsigned errors       = 0;
	int unsigned cycles       = 0;
	int unsigned results_seen = 0;
	logic        req_taken    = 1'b0;
	logic        rsp_taken    = 1'b0;

	int unsigned send_gap  = 0;
	int unsigned send_calm = 0;
	int unsigned hold_left = 0;
	int unsigned rsp_calm  = 0;
	logic        long_hold_done = 1'b0;

	task automatic report_mismatch(input string what);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= bcse_pkg::CH_UP_A && b <= bcse_pkg::CH_UP_Z) ||
		       (b >= bcse_pkg::CH_LO_A && b <= bcse_pkg::CH_LO_Z);
	endfunction

	// Most waits are short random draws; now and then a run of zero waits gives back-to-back traffic
	function automatic int unsigned draw_wait(inout int unsigned calm_left);
		if (calm_left != 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(20, 80);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	// Advance the shadow state by one accepted request; queue the response a cover byte owes
	task automatic encode_request(input bcse_pkg::req_t r);
		bcse_pkg::rsp_t res;
		logic [7:0]     up;
		logic [4:0]     code;
		logic           hit;
		if (r.func == bcse_pkg::FUNC_LOAD) begin
			// fold lower case onto upper case, then look the character up
			up   = (r.data >= bcse_pkg::CH_LO_A && r.data <= bcse_pkg::CH_LO_Z) ?
			       (r.data & ~bcse_pkg::CASE_BIT) : r.data;
			hit  = 1'b1;
			code = '0;
			if (up >= bcse_pkg::CH_UP_A && up <= bcse_pkg::CH_UP_Z) begin
				code = 5'(up - bcse_pkg::CH_UP_A);
			end else begin
				case (up)
					bcse_pkg::CH_DOT:   code = bcse_pkg::CODE_DOT;
					bcse_pkg::CH_SEMI:  code = bcse_pkg::CODE_SEMI;
					bcse_pkg::CH_BANG:  code = bcse_pkg::CODE_BANG;
					bcse_pkg::CH_QUERY: code = bcse_pkg::CODE_QUERY;
					bcse_pkg::CH_ZERO:  code = bcse_pkg::CODE_ZERO;
					bcse_pkg::CH_SPACE: code = bcse_pkg::CODE_SPACE;
					default:            hit = 1'b0;
				endcase
			end
			// drop unmapped characters and anything past a full buffer
			if (hit && code_fill < MSG_DEPTH) begin
				code_buf[code_fill] = code;
				code_fill++;
			end
		end else begin
			res.out_byte    = r.data;
			res.all_placed  = 1'b0;
			res.end_of_text = r.last;
			if (is_alpha(r.data) && code_pos < code_fill) begin
				// message bit 1 gives lower case, 0 upper case, MSB of each code first
				if (code_buf[code_pos][3'd4 - bit_pos])
					res.out_byte = r.data | bcse_pkg::CASE_BIT;
				else
					res.out_byte = r.data & ~bcse_pkg::CASE_BIT;
				if (bit_pos == 3'd4) begin
					bit_pos = '0;
					code_pos++;
				end else begin
					bit_pos++;
				end
			end
			if (r.last) begin
				res.all_placed = (code_pos >= code_fill) && (bit_pos == '0);
				code_fill      = 0;
				code_pos       = 0;
				bit_pos        = '0;
			end
			expected_cover.insert(expected_cover.size(), res);
		end
	endtask

	task automatic queue_request(input logic f, input logic [7:0] d, input logic l);
		bcse_pkg::req_t r;
		r.func = f;
		r.data = d;
		r.last = l;
		request_backlog.insert(request_backlog.size(), r);
	endtask

	// Message characters: mostly mapped, in either case; now and then any byte at all
	function automatic logic [7:0] pick_message_char();
		logic [7:0] punct [6];
		punct = '{bcse_pkg::CH_DOT, bcse_pkg::CH_SEMI, bcse_pkg::CH_BANG,
		          bcse_pkg::CH_QUERY, bcse_pkg::CH_ZERO, bcse_pkg::CH_SPACE};
		case ($urandom_range(0, 5))
			0, 1:    return bcse_pkg::CH_UP_A + 8'($urandom_range(0, 25));
			2, 3:    return bcse_pkg::CH_LO_A + 8'($urandom_range(0, 25));
			4:       return punct[$urandom_range(0, 5)];
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_letter();
		return ($urandom_range(0, 1) ? bcse_pkg::CH_UP_A : bcse_pkg::CH_LO_A) +
		       8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] pick_other();
		logic [7:0] b;
		b = 8'($urandom);
		while (is_alpha(b))
			b = 8'($urandom);
		return b;
	endfunction

	// One message followed by a cover text that ends on a last byte.
	// The cover carries fewer, exactly enough, or more letters than the message needs.
	task automatic queue_message_and_cover(input int unsigned msg_len);
		int unsigned letters_left;
		int unsigned others_left;
		logic        pick_alpha;
		for (int unsigned i = 0; i < msg_len; i++)
			queue_request(bcse_pkg::FUNC_LOAD, pick_message_char(), $urandom_range(0, 7) == 0);
		letters_left = msg_len * 5;
		case ($urandom_range(0, 3))
			0:       letters_left = $urandom_range(0, letters_left);
			1:       ;
			default: letters_left = letters_left + $urandom_range(0, 10);
		endcase
		others_left = $urandom_range(0, letters_left / 2 + 3);
		if (letters_left + others_left == 0)
			others_left = 1;
		while (letters_left + others_left != 0) begin
			// slip the odd message character in mid-stream
			if ($urandom_range(0, 39) == 0)
				queue_request(bcse_pkg::FUNC_LOAD, pick_message_char(), 1'b0);
			pick_alpha = (letters_left != 0) && (others_left == 0 || $urandom_range(0, 3) != 0);
			if (pick_alpha)
				letters_left--;
			else
				others_left--;
			queue_request(bcse_pkg::FUNC_COVER, pick_alpha ? pick_letter() : pick_other(),
				letters_left + others_left == 0);
		end
	endtask

	// Request side: hold the payload while stalled, draw a gap after each accepted request
	always @(negedge clk) begin : drive_proc
		logic next_valid;
		next_valid = req_valid;
		if (arst_n) begin
			if (req_valid && req_taken) begin
				next_valid = 1'b0;
				send_gap   = draw_wait(send_calm);
			end
			if (!next_valid) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (request_backlog.size() != 0) begin
					req        <= request_backlog.pop_front();
					next_valid = 1'b1;
				end
			end
		end
		req_valid <= next_valid;
	end

	// Response side: draw a stall after each accepted response; once, hold off long enough for the
	// block to back up and stall its request side
	always @(negedge clk) begin : stall_proc
		if (rsp_taken) begin
			hold_left = draw_wait(rsp_calm);
			if (!long_hold_done && results_seen >= 300) begin
				hold_left      = LONG_HOLD;
				long_hold_done = 1'b1;
			end
		end else if (hold_left != 0) begin
			hold_left--;
		end
		rsp_stall <= (hold_left != 0);
	end

	// Sample both handshakes, predict from accepted requests, check accepted responses
	always @(posedge clk) begin : watch_proc
		bcse_pkg::rsp_t want;
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end else begin
			req_taken = arst_n && req_valid && !req_stall;
			rsp_taken = arst_n && rsp_valid && !rsp_stall;
			if (req_taken)
				encode_request(req);
			if (rsp_taken) begin
				results_seen++;
				if (expected_cover.size() == 0) begin
					report_mismatch($sformatf("unexpected response %h", rsp));
				end else begin
					want = expected_cover.pop_front();
					if (rsp.out_byte !== want.out_byte)
						report_mismatch($sformatf("out_byte %h, want %h",
							rsp.out_byte, want.out_byte));
					if (rsp.all_placed !== want.all_placed)
						report_mismatch($sformatf("all_placed %b, want %b",
							rsp.all_placed, want.all_placed));
					if (rsp.end_of_text !== want.end_of_text)
						report_mismatch($sformatf("end_of_text %b, want %b",
							rsp.end_of_text, want.end_of_text));
				end
			end
		end
	end

	initial begin : stimulus_proc
		logic full_done;
		full_done = 1'b0;

		// Empty message: bytes pass unchanged and the last one reports everything placed
		queue_request(bcse_pkg::FUNC_COVER, bcse_pkg::CH_LO_A, 1'b0);
		queue_request(bcse_pkg::FUNC_COVER, bcse_pkg::CH_UP_Z, 1'b1);

		// Every mapped class, a last flag on a load (ignored), and unmapped bytes (dropped)
		queue_request(bcse_pkg::FUNC_LOAD, bcse_pkg::CH_LO_A, 1'b1);
		queue_request(bcse_pkg::FUNC_LOAD, bcse_pkg::CH_UP_Z, 1'b0);
		queue_request(bcse_pkg::FUNC_LOAD, bcse_pkg::CH_DOT, 1'b0);
		queue_request(bcse_pkg::FUNC_LOAD, bcse_pkg::CH_SEMI, 1'b0);
		queue_request(bcse_pkg::FUNC_LOAD, bcse_pkg::CH_BANG, 1'b0);
		queue_request(bcse_pkg::FUNC_LOAD, bcse_pkg::CH_QUERY, 1'b0);
		queue_request(bcse_pkg::FUNC_LOAD, bcse_pkg::CH_ZERO, 1'b0);
		queue_request(bcse_pkg::FUNC_LOAD, bcse_pkg::CH_SPACE, 1'b0);
		queue_request(bcse_pkg::FUNC_LOAD, 8'h23, 1'b0);
		queue_request(bcse_pkg::FUNC_LOAD, 8'hFF, 1'b0);

		// Short cover: letter boundaries, non-ASCII and zero bytes; the message is left unplaced
		queue_request(bcse_pkg::FUNC_COVER, bcse_pkg::CH_UP_A, 1'b0);
		queue_request(bcse_pkg::FUNC_COVER, bcse_pkg::CH_LO_Z, 1'b0);
		queue_request(bcse_pkg::FUNC_COVER, 8'h40, 1'b0);
		queue_request(bcse_pkg::FUNC_COVER, 8'h5B, 1'b0);
		queue_request(bcse_pkg::FUNC_COVER, 8'h60, 1'b0);
		queue_request(bcse_pkg::FUNC_COVER, 8'h7B, 1'b0);
		queue_request(bcse_pkg::FUNC_COVER, 8'h80, 1'b0);
		queue_request(bcse_pkg::FUNC_COVER, 8'hFF, 1'b0);
		queue_request(bcse_pkg::FUNC_COVER, 8'h00, 1'b0);
		queue_request(bcse_pkg::FUNC_COVER, bcse_pkg::CH_LO_Z, 1'b0);
		queue_request(bcse_pkg::FUNC_COVER, bcse_pkg::CH_UP_A, 1'b1);

		// Random part: mostly well-formed message and cover pairs, some raw noise,
		// and one message long enough to overflow the code buffer
		while (request_backlog.size() < STOP_AFTER) begin
			if (!full_done && request_backlog.size() > 800) begin
				full_done = 1'b1;
				for (int unsigned i = 0; i < MSG_DEPTH + 44; i++)
					queue_request(bcse_pkg::FUNC_LOAD, pick_letter(), 1'b0);
				for (int unsigned i = 0; i < 40; i++)
					queue_request(bcse_pkg::FUNC_COVER, pick_letter(), i == 39);
			end else if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 10))
					queue_request(1'($urandom), 8'($urandom), $urandom_range(0, 7) == 0);
			end else begin
				queue_message_and_cover($urandom_range(0, 12));
			end
		end

		// Hold reset, then release it away from the rising edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain: everything offered, everything answered, then a wait for stragglers
		while (request_backlog.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_cover.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
